### rtl/core/mcr_pkg.sv
// Shared constants and types for the midpoint circle rasterizer.
package mcr_pkg;

	localparam int COORD_BITS_DEF = 12;

	// signed width of every emitted coordinate
	localparam int PIX_W       = 14;
	localparam int BORDER_W    = 5;
	localparam int OUT_FIELDS_W = 3 * PIX_W;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELDS_W;
	localparam int OUT_TUSER_W = 2;

	// configuration register indexes
	localparam logic CFG_FILL   = 1'b0;
	localparam logic CFG_BORDER = 1'b1;

	// input action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// result kind codes
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_SPAN  = 1'b1;

	// word index within one step: four spans, then eight octant pixels
	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] IDX_S0 = 4'd0;
	localparam logic [IDX_W-1:0] IDX_S1 = 4'd1;
	localparam logic [IDX_W-1:0] IDX_S2 = 4'd2;
	localparam logic [IDX_W-1:0] IDX_S3 = 4'd3;
	localparam logic [IDX_W-1:0] IDX_P0 = 4'd4;
	localparam logic [IDX_W-1:0] IDX_P1 = 4'd5;
	localparam logic [IDX_W-1:0] IDX_P2 = 4'd6;
	localparam logic [IDX_W-1:0] IDX_P3 = 4'd7;
	localparam logic [IDX_W-1:0] IDX_P4 = 4'd8;
	localparam logic [IDX_W-1:0] IDX_P5 = 4'd9;
	localparam logic [IDX_W-1:0] IDX_P6 = 4'd10;
	localparam logic [IDX_W-1:0] IDX_P7 = 4'd11;

	typedef struct packed {
		logic load;   // take a new step snapshot
		logic fill;   // emit spans first
		logic done;   // this step finishes the circle
	} mcr_job_t;

endpackage

### rtl/core/midpoint_circle_rasterizer_unit.sv
// Top level of the midpoint circle rasterizer: loop state, decision update, config.
//
// channel  | dir | handshake             | content
// s_axis   | in  | tvalid/tready         | tdata: center_x, center_y, radius; tuser: action
// m_axis   | out | tvalid/tready         | tdata: x_start, y_pos, x_end; tuser: kind, done_res; tlast
// cfg      | in  | cfg_we (no wait)      | cfg_index selects fill_mode or border_size, cfg_data
//
// A start word produces nothing. A step word produces 8 words, or 12 with fill on, one per cycle
// from the output register while m_axis does not stall; the next word is taken in the cycle the
// last of those enters the output register, so a new step word waits until the word sequencer is
// through with the last. The loop update is done when the step is taken. Reset clears the loop
// state and fill mode and sets border_size to 1; m_axis stalls hold the output word in place.
module midpoint_circle_rasterizer_unit #(
	parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF,
	parameter int IN_TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// center_x, center_y, radius, zero pad
	input  logic [IN_TDATA_W-1:0]            s_axis_tdata,
	// action
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// x_start, y_pos, x_end, zero pad
	output logic [mcr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// kind, done_res
	output logic [mcr_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
	output logic                             m_axis_tlast,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [mcr_pkg::BORDER_W-1:0]     cfg_data
);
	import mcr_pkg::*;

	localparam int LOOP_W = COORD_BITS + 1;
	localparam int ERR_W  = COORD_BITS + 4;

	logic [COORD_BITS-1:0]     cx_q, cy_q;
	logic signed [LOOP_W-1:0]  xcur_q, ycur_q;
	logic signed [ERR_W-1:0]   err_q;
	logic                      active_q;
	logic                      fill_q;
	logic [BORDER_W-1:0]       border_q;

	logic [COORD_BITS-1:0]     in_cx, in_cy, in_r;
	logic                      accept, start_go, step_go, emit_free;
	logic signed [LOOP_W-1:0]  x_inc, y_inc, x_n, y_n;
	logic signed [ERR_W-1:0]   err_n;
	logic                      done_n;
	mcr_job_t                  job;

	assign in_cx = s_axis_tdata[COORD_BITS-1:0];
	assign in_cy = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign in_r  = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];

	assign s_axis_tready = emit_free;
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign start_go = accept && (s_axis_tuser == ACT_START);
	assign step_go  = accept && (s_axis_tuser == ACT_STEP) && active_q;

	// midpoint decision: move y when the term is not positive, else move x
	always_comb begin
		y_inc = ycur_q + LOOP_W'(1);
		x_inc = xcur_q - LOOP_W'(1);
		if (err_q <= 0) begin
			x_n   = xcur_q;
			y_n   = y_inc;
			err_n = err_q + ERR_W'($signed({y_inc, 1'b1}));
		end else begin
			x_n   = x_inc;
			y_n   = ycur_q;
			err_n = err_q - ERR_W'($signed({x_inc, 1'b1}));
		end
		done_n = (x_n < y_n);
	end

	assign job.load = step_go;
	assign job.fill = fill_q;
	assign job.done = done_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			xcur_q   <= '0;
			ycur_q   <= '0;
			err_q    <= '0;
			active_q <= 1'b0;
			fill_q   <= 1'b0;
			border_q <= BORDER_W'(1);
		end else begin
			if (start_go) begin
				cx_q     <= in_cx;
				cy_q     <= in_cy;
				xcur_q   <= $signed({1'b0, in_r});
				ycur_q   <= '0;
				err_q    <= '0;
				active_q <= 1'b1;
			end else if (step_go) begin
				xcur_q   <= x_n;
				ycur_q   <= y_n;
				err_q    <= err_n;
				active_q <= !done_n;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_FILL:   fill_q   <= cfg_data[0];
					CFG_BORDER: border_q <= cfg_data;
					default:    fill_q   <= fill_q;
				endcase
			end
		end
	end

	mcr_emit #(
		.COORD_BITS(COORD_BITS)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (job),
		.cx            (cx_q),
		.cy            (cy_q),
		.xc            (xcur_q),
		.yc            (ycur_q),
		.border        (border_q),
		.free          (emit_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_start_activates: assert property (@(posedge clk) disable iff (!arst_n)
		start_go |=> active_q && (ycur_q == 0) && (err_q == 0))
		else $error("start did not arm the loop");

	a_step_moves_one: assert property (@(posedge clk) disable iff (!arst_n)
		step_go |=> (xcur_q != $past(xcur_q)) != (ycur_q != $past(ycur_q)))
		else $error("step must move exactly one loop coordinate");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_go && done_n |=> !active_q)
		else $error("finished circle still active");

endmodule

### rtl/core/mcr_emit.sv
// Step snapshot, word sequencer and output register of the circle rasterizer.
module mcr_emit #(
	parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mcr_pkg::mcr_job_t                job,
	input  logic [COORD_BITS-1:0]            cx,
	input  logic [COORD_BITS-1:0]            cy,
	input  logic signed [COORD_BITS:0]       xc,
	input  logic signed [COORD_BITS:0]       yc,
	input  logic [mcr_pkg::BORDER_W-1:0]     border,
	output logic                             free,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// x_start, y_pos, x_end, zero pad
	output logic [mcr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// kind, done_res
	output logic [mcr_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
	output logic                             m_axis_tlast
);
	import mcr_pkg::*;

	logic                      job_valid_q;
	logic                      done_q;
	logic [COORD_BITS-1:0]     cx_q, cy_q;
	logic signed [COORD_BITS:0] x_q, y_q;
	logic [BORDER_W-1:0]       b_q;
	logic [IDX_W-1:0]          idx_q;

	logic                      out_valid_q;
	logic [OUT_TDATA_W-1:0]    tdata_q;
	logic [OUT_TUSER_W-1:0]    tuser_q;
	logic                      tlast_q;

	logic out_load;
	logic is_final;

	logic signed [PIX_W-1:0] xe, ye, cxe, cye, be;
	logic signed [PIX_W-1:0] a_v, c_v, u_v, v_v;
	logic signed [PIX_W-1:0] xs_n, yp_n, xend_n;
	logic                    kind_n;

	assign out_load = job_valid_q && (!out_valid_q || m_axis_tready);
	assign is_final = (idx_q == IDX_P7);
	assign free     = !job_valid_q || (out_load && is_final);

	assign cxe = PIX_W'($signed({1'b0, cx_q}));
	assign cye = PIX_W'($signed({1'b0, cy_q}));
	assign xe  = PIX_W'(x_q);
	assign ye  = PIX_W'(y_q);
	assign be  = PIX_W'($signed({1'b0, b_q}));

	always_comb begin
		a_v    = (idx_q inside {IDX_S0, IDX_S3}) ? xe : ye;
		c_v    = (idx_q inside {IDX_S0, IDX_S3}) ? ye : xe;
		u_v    = (idx_q inside {IDX_P0, IDX_P3, IDX_P4, IDX_P7}) ? xe : ye;
		v_v    = (idx_q inside {IDX_P0, IDX_P3, IDX_P4, IDX_P7}) ? ye : xe;
		kind_n = KIND_PIXEL;
		xs_n   = '0;
		yp_n   = '0;
		xend_n = '0;
		case (idx_q)
			IDX_S0, IDX_S1, IDX_S2, IDX_S3: begin
				kind_n = KIND_SPAN;
				xs_n   = cxe - a_v + be - PIX_W'(1);
				xend_n = cxe + a_v - be;
				yp_n   = (idx_q inside {IDX_S0, IDX_S1}) ? (cye + c_v - be) : (cye - c_v + be);
			end
			IDX_P0, IDX_P1, IDX_P2, IDX_P3, IDX_P4, IDX_P5, IDX_P6, IDX_P7: begin
				kind_n = KIND_PIXEL;
				xs_n   = (idx_q inside {IDX_P0, IDX_P1, IDX_P6, IDX_P7}) ? (cxe + u_v) : (cxe - u_v);
				xend_n = xs_n;
				yp_n   = (idx_q inside {IDX_P0, IDX_P1, IDX_P2, IDX_P3}) ? (cye + v_v) : (cye - v_v);
			end
			default: begin
				kind_n = KIND_PIXEL;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= IDX_S0;
			out_valid_q <= 1'b0;
		end else begin
			if (job.load) begin
				job_valid_q <= 1'b1;
				idx_q       <= job.fill ? IDX_S0 : IDX_P0;
			end else if (out_load && is_final) begin
				job_valid_q <= 1'b0;
			end else if (out_load) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (job.load) begin
			done_q <= job.done;
			cx_q   <= cx;
			cy_q   <= cy;
			x_q    <= xc;
			y_q    <= yc;
			b_q    <= border;
		end
		if (out_load) begin
			tdata_q <= {{OUT_PAD_W{1'b0}}, xend_n, yp_n, xs_n};
			tuser_q <= {done_q && is_final, kind_n};
			tlast_q <= is_final;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;
	assign m_axis_tlast  = tlast_q;

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		job.load |-> free)
		else $error("snapshot loaded while words still pending");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> (idx_q <= IDX_P7))
		else $error("word index past last pixel");

	a_final_sets_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && is_final |=> m_axis_tvalid && m_axis_tlast)
		else $error("final word without tlast");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("done flag on a word that is not last");

endmodule
